/* hw/rtl/htenc_pkg.sv */
// shared types and constants of the huffman table encoder
`timescale 1ns / 1ps

package htenc_pkg;

    // table geometry
    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int SYM_AW       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int SYM_W   = 8;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int MODE_W  = 2;
    localparam int POS_W   = 3;

    // longest code that can be stored
    localparam int LEN_CAP = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;

    // one table entry: length over code word
    localparam int ENTRY_W = LEN_W + CODE_W;

    // pending byte followed by one full code word
    localparam int ACC_W     = BYTE_W + CODE_W;
    localparam int MAX_BYTES = (BYTE_W - 1 + LEN_CAP) / BYTE_W;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    // item modes
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

    // input transaction
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_len;
    } item_t;

    // output transaction
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } result_t;

    // lookup stage control handed to the packer
    typedef struct packed {
        logic vld;
        logic flush;
        logic hit;
    } lookup_t;

endpackage

/* hw/rtl/htenc_ram.sv */
// generic single-port ram with registered read
`timescale 1ns / 1ps

module htenc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/htenc_packer.sv */
// msb-first bit packer and byte emitter
`timescale 1ns / 1ps

module htenc_packer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  htenc_pkg::lookup_t             lookup,
    input  logic [htenc_pkg::ENTRY_W-1:0]  entry,
    output logic                           take,
    output logic                           result_valid,
    input  logic                           result_ready,
    output htenc_pkg::result_t             result
);

    logic [htenc_pkg::BYTE_W-1:0] pending_reg, pending_next;
    logic [htenc_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [htenc_pkg::ACC_W-1:0]  word_reg, word_next;
    logic [htenc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    logic [htenc_pkg::LEN_W-1:0]  n;
    logic [htenc_pkg::CODE_W-1:0] code;
    logic [htenc_pkg::CODE_W:0]   mask_wide;
    logic [htenc_pkg::CODE_W-1:0] code_m;
    logic [6:0]                   shamt;
    logic [htenc_pkg::ACC_W-1:0]  aligned;
    logic [htenc_pkg::ACC_W-1:0]  merged;
    logic [htenc_pkg::LEN_W-1:0]  total;
    logic [htenc_pkg::CNT_W-1:0]  nbytes;
    logic                         out_fire;

    // code bits of the looked-up entry, masked to its length
    always_comb
    begin
        n         = lookup.hit ? entry[htenc_pkg::ENTRY_W-1 -: htenc_pkg::LEN_W] : '0;
        code      = entry[htenc_pkg::CODE_W-1:0];
        mask_wide = ((htenc_pkg::CODE_W+1)'(1) << n) - (htenc_pkg::CODE_W+1)'(1);
        code_m    = code & mask_wide[htenc_pkg::CODE_W-1:0];
    end

    // place the code right below the pending bits
    always_comb
    begin
        shamt   = 7'(htenc_pkg::ACC_W) - 7'(pos_reg) - 7'(n);
        aligned = {{htenc_pkg::BYTE_W{1'b0}}, code_m} << shamt;
        merged  = {pending_reg, {htenc_pkg::CODE_W{1'b0}}} | aligned;
        total   = htenc_pkg::LEN_W'(pos_reg) + n;
    end

    // emitter frees up when it is empty or its last byte leaves now
    assign out_fire = result_valid && result_ready;
    assign take     = (cnt_reg == '0) ||
                      (cnt_reg == htenc_pkg::CNT_W'(1) && result_ready);

    // next packer and emitter state
    always_comb
    begin
        pending_next = pending_reg;
        pos_next     = pos_reg;
        word_next    = word_reg;
        cnt_next     = cnt_reg;
        nbytes       = total[htenc_pkg::LEN_W-1:htenc_pkg::POS_W];
        if (out_fire)
        begin
            word_next = word_reg << htenc_pkg::BYTE_W;
            cnt_next  = cnt_reg - htenc_pkg::CNT_W'(1);
        end
        if (lookup.vld && take)
        begin
            if (lookup.flush)
            begin
                word_next    = {pending_reg, {htenc_pkg::CODE_W{1'b0}}};
                cnt_next     = (pos_reg != '0) ? htenc_pkg::CNT_W'(1) : '0;
                pending_next = '0;
                pos_next     = '0;
            end
            else
            begin
                word_next    = merged;
                cnt_next     = nbytes;
                pending_next = merged[htenc_pkg::ACC_W-1-htenc_pkg::BYTE_W*nbytes -:
                                      htenc_pkg::BYTE_W];
                pos_next     = total[htenc_pkg::POS_W-1:0];
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            pos_reg     <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            pos_reg     <= pos_next;
            cnt_reg     <= cnt_next;
        end
    end

    // byte shift register
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // output transaction
    assign result_valid    = (cnt_reg != '0);
    assign result.out_byte = word_reg[htenc_pkg::ACC_W-1 -: htenc_pkg::BYTE_W];
    assign result.last     = (cnt_reg == htenc_pkg::CNT_W'(1));

`ifndef ASSERT_OFF
    // never more bytes queued than one item can cause
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= htenc_pkg::CNT_W'(htenc_pkg::MAX_BYTES))
        else $error("emitter byte count out of range");

    // a flush leaves no pending bits
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (lookup.vld && lookup.flush && take) |=> (pos_reg == '0 && pending_reg == '0))
        else $error("pending bits left after flush");

    // a waiting byte holds until it is taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result)))
        else $error("output transaction changed while waiting");
`endif

endmodule

/* hw/rtl/huffman_table_encoder_unit.sv */
// huffman table encoder top level: code table, lookup stage and packer
`timescale 1ns / 1ps

// Table-driven Huffman encoder. A load item writes one symbol's code word and
// length into an on-chip table (one 38-bit entry per symbol, lengths above 32
// stored as 32); an encode item reads the entry and appends the code, most
// significant code bit first, to an MSB-first byte packer; a flush item pads
// the pending bits with zeros and sends them as a final byte. Every byte
// leaves as one output transaction, and last marks the final byte caused by
// an item. Lengths read as zero until a symbol is loaded, through a row of
// per-symbol valid flops cleared by reset, so no clearing pass is needed and
// the block takes items right after reset. Items are taken one per cycle
// while the lookup stage is free: a load never enters it, and an encode or
// flush waits there until the single byte emitter is empty or its last byte
// leaves; the emitter drains one byte per cycle while the receiver is ready,
// and an item completes at most 4 bytes. Table reads are registered.
module huffman_table_encoder_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  htenc_pkg::item_t    item,
    output logic                result_valid,
    input  logic                result_ready,
    output htenc_pkg::result_t  result
);

    logic                                 accept;
    logic                                 sym_ok;
    logic                                 is_load;
    logic                                 is_encode;
    logic                                 is_flush;
    logic [htenc_pkg::SYM_AW-1:0]         idx;
    logic [htenc_pkg::LEN_W-1:0]          len_capped;
    logic                                 ram_we;
    logic                                 ram_re;
    logic [htenc_pkg::ENTRY_W-1:0]        entry;
    logic                                 take;
    logic [htenc_pkg::SYMBOL_COUNT-1:0]   loaded_reg, loaded_next;
    htenc_pkg::lookup_t                   lookup_reg, lookup_next;

    // input decode
    always_comb
    begin
        sym_ok     = ({1'b0, item.symbol} < 9'(htenc_pkg::SYMBOL_COUNT));
        is_load    = (item.mode == htenc_pkg::MODE_LOAD);
        is_encode  = (item.mode == htenc_pkg::MODE_ENCODE);
        is_flush   = (item.mode == htenc_pkg::MODE_FLUSH);
        idx        = item.symbol[htenc_pkg::SYM_AW-1:0];
        len_capped = (item.code_len > htenc_pkg::LEN_W'(htenc_pkg::LEN_CAP)) ?
                     htenc_pkg::LEN_W'(htenc_pkg::LEN_CAP) : item.code_len;
    end

    // input handshake: lookup stage frees when the packer takes it
    assign item_ready = !lookup_reg.vld || take;
    assign accept     = item_valid && item_ready;
    assign ram_we     = accept && is_load && sym_ok;
    assign ram_re     = accept && is_encode && sym_ok;

    // code table memory
    htenc_ram #(
        .DATA_W (htenc_pkg::ENTRY_W),
        .DEPTH  (htenc_pkg::SYMBOL_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (idx),
        .wdata ({len_capped, item.code_bits}),
        .rdata (entry)
    );

    // loaded flags and lookup stage control
    always_comb
    begin
        loaded_next = loaded_reg;
        if (ram_we)
        begin
            loaded_next[idx] = 1'b1;
        end
        lookup_next = lookup_reg;
        if (item_ready)
        begin
            lookup_next.vld   = accept && ((is_encode && sym_ok) || is_flush);
            lookup_next.flush = is_flush;
            lookup_next.hit   = loaded_reg[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
            lookup_reg <= '0;
        end
        else
        begin
            loaded_reg <= loaded_next;
            lookup_reg <= lookup_next;
        end
    end

    // packer and byte emitter
    htenc_packer u_packer (
        .clk          (clk),
        .rst_n        (rst_n),
        .lookup       (lookup_reg),
        .entry        (entry),
        .take         (take),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef ASSERT_OFF
    // a table read always lands in the lookup stage as an encode
    a_read_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> (lookup_reg.vld && !lookup_reg.flush))
        else $error("table read without an encode in the lookup stage");

    // loads never occupy the lookup stage
    a_load_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_encode && !is_flush) |=> !lookup_reg.vld)
        else $error("load or unused mode entered the lookup stage");

    // a stall only comes from a busy lookup stage
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (lookup_reg.vld && result_valid))
        else $error("input stalled with idle lookup stage");

    // the table entry under lookup holds while the stage waits
    a_entry_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (lookup_reg.vld && !take) |=> $stable(entry))
        else $error("table data changed under a stalled lookup");
`endif

endmodule

/* tb/sv/huffman_table_encoder_unit_test.sv */
// testbench for the huffman table encoder: table loads, symbol encodes and flushes
`timescale 1ns / 1ps

module huffman_table_encoder_unit_test;

    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AT     = 170;
    localparam int TAIL_CYCLES = 16;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_ready;
    htenc_pkg::item_t   item         = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    htenc_pkg::result_t result;

    // pending transactions and their pause-for-drain marks
    htenc_pkg::item_t   symbol_items_q[$];
    bit                 drain_first_q[$];
    int                 item_total = 0;

    // predicted output bytes, oldest first
    htenc_pkg::result_t packed_bytes_q[$];

    // encoder state as seen by the predictor
    logic [htenc_pkg::CODE_W-1:0] code_word_tab[htenc_pkg::SYMBOL_COUNT];
    logic [htenc_pkg::LEN_W-1:0]  code_len_tab[htenc_pkg::SYMBOL_COUNT];
    logic [htenc_pkg::BYTE_W-1:0] pend_byte = '0;
    int                           pend_cnt  = 0;

    // symbols loaded so far while building stimulus
    bit   sym_loaded[htenc_pkg::SYMBOL_COUNT];
    int   loaded_syms_q[$];

    int   taken_cnt    = 0;
    int   mismatch_cnt = 0;
    bit   item_fire    = 1'b0;
    int   hold_left    = 0;
    bit   hold_done    = 1'b0;

    huffman_table_encoder_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // idling per phase of the run
    function automatic int sender_idle_pct(input int n);
        case ((n / 40) % 5)
            1: return 77;
            3: return 29;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(input int n);
        case ((n / 40) % 5)
            2: return 77;
            3: return 29;
            default: return 0;
        endcase
    endfunction

    // queue one transaction, tracking which symbols have a table entry
    task automatic add_item(input logic [htenc_pkg::MODE_W-1:0] mode, input int sym,
                            input logic [htenc_pkg::CODE_W-1:0] bits, input int len,
                            input bit drain);
        htenc_pkg::item_t it;
        it.mode      = mode;
        it.symbol    = sym[htenc_pkg::SYM_W-1:0];
        it.code_bits = bits;
        it.code_len  = len[htenc_pkg::LEN_W-1:0];
        symbol_items_q.insert(symbol_items_q.size(), it);
        drain_first_q.insert(drain_first_q.size(), drain);
        item_total++;
        if (mode == htenc_pkg::MODE_LOAD && !sym_loaded[sym])
        begin
            sym_loaded[sym] = 1'b1;
            loaded_syms_q.insert(loaded_syms_q.size(), sym);
        end
    endtask

    // random code length, mostly short, some long, a few overlong
    function automatic int pick_code_len();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 0;
        else if (r < 70)
            return $urandom_range(12, 1);
        else if (r < 92)
            return $urandom_range(32, 13);
        return $urandom_range(63, 33);
    endfunction

    // predict the bytes that one accepted transaction produces
    task automatic predict_bytes(input htenc_pkg::item_t it);
        int                 n;
        int                 i;
        int                 made;
        htenc_pkg::result_t r;
        made = 0;
        case (it.mode)
            htenc_pkg::MODE_LOAD:
            begin
                code_word_tab[it.symbol] = it.code_bits;
                code_len_tab[it.symbol]  =
                    (it.code_len > htenc_pkg::LEN_CAP) ?
                    htenc_pkg::LEN_W'(htenc_pkg::LEN_CAP) : it.code_len;
            end
            htenc_pkg::MODE_ENCODE:
            begin
                n = code_len_tab[it.symbol];
                for (i = n; i > 0; i--)
                begin
                    pend_byte[7 - pend_cnt] = code_word_tab[it.symbol][i - 1];
                    pend_cnt++;
                    if (pend_cnt == 8)
                    begin
                        r.out_byte = pend_byte;
                        r.last     = 1'b0;
                        packed_bytes_q.insert(packed_bytes_q.size(), r);
                        made++;
                        pend_byte = '0;
                        pend_cnt  = 0;
                    end
                end
                if (made > 0)
                begin
                    packed_bytes_q[packed_bytes_q.size() - 1].last = 1'b1;
                end
            end
            htenc_pkg::MODE_FLUSH:
            begin
                if (pend_cnt != 0)
                begin
                    r.out_byte = pend_byte;
                    r.last     = 1'b1;
                    packed_bytes_q.insert(packed_bytes_q.size(), r);
                    pend_byte = '0;
                    pend_cnt  = 0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // input driver, changes at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || item_fire)
        begin
            if (symbol_items_q.size() > 0
                && !(drain_first_q[0] && packed_bytes_q.size() > 0)
                && $urandom_range(99) >= sender_idle_pct(taken_cnt))
            begin
                item <= symbol_items_q[0];
                symbol_items_q.delete(0);
                drain_first_q.delete(0);
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // output receiver, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (!hold_done && taken_cnt >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= receiver_stall_pct(taken_cnt));
        end
    end

    // monitor: predict on input transactions, check output transactions
    always @(posedge clk)
    begin
        htenc_pkg::result_t exp_byte;
        item_fire = rst_n && item_valid && item_ready;
        if (item_fire)
        begin
            predict_bytes(item);
            taken_cnt++;
        end
        if (rst_n && result_valid && result_ready)
        begin
            if (packed_bytes_q.size() == 0)
            begin
                $error("unexpected byte: out_byte %h last %b", result.out_byte, result.last);
                mismatch_cnt++;
            end
            else
            begin
                exp_byte = packed_bytes_q[0];
                packed_bytes_q.delete(0);
                if (result.out_byte !== exp_byte.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", exp_byte.out_byte,
                           result.out_byte);
                    mismatch_cnt++;
                end
                if (result.last !== exp_byte.last)
                begin
                    $error("last: expected %b, got %b", exp_byte.last, result.last);
                    mismatch_cnt++;
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int useful;
        int sym;
        logic [htenc_pkg::MODE_W-1:0] unused_mode;
        unused_mode = '1;

        // length table starts out cleared
        for (int k = 0; k < htenc_pkg::SYMBOL_COUNT; k++)
            code_len_tab[k] = '0;

        // directed: field extremes, saturation, empty and partial flushes
        add_item(htenc_pkg::MODE_ENCODE, 7, $urandom, $urandom_range(63), 1'b0);
        add_item(htenc_pkg::MODE_LOAD, 0, 32'h0000_0001, 1, 1'b0);
        add_item(htenc_pkg::MODE_LOAD, 255, 32'hFFFF_FFFF, 32, 1'b0);
        add_item(htenc_pkg::MODE_LOAD, 1, 32'h0000_0000, 32, 1'b0);
        add_item(htenc_pkg::MODE_LOAD, 2, 32'h0000_00A5, 8, 1'b0);
        add_item(htenc_pkg::MODE_LOAD, 3, 32'hB2C3_D4E5, 63, 1'b0);
        add_item(htenc_pkg::MODE_LOAD, 4, 32'hDEAD_BEEF, 0, 1'b0);
        add_item(htenc_pkg::MODE_LOAD, 5, 32'h0000_0005, 3, 1'b0);
        add_item(htenc_pkg::MODE_LOAD, 6, 32'h5555_5555, 33, 1'b0);
        add_item(htenc_pkg::MODE_ENCODE, 0, $urandom, $urandom_range(63), 1'b0);
        add_item(htenc_pkg::MODE_FLUSH, 0, $urandom, $urandom_range(63), 1'b0);
        add_item(htenc_pkg::MODE_FLUSH, 255, $urandom, $urandom_range(63), 1'b0);
        add_item(htenc_pkg::MODE_ENCODE, 255, 32'hFFFF_FFFF, 63, 1'b0);
        add_item(htenc_pkg::MODE_ENCODE, 1, 32'h0000_0000, 0, 1'b0);
        add_item(htenc_pkg::MODE_ENCODE, 0, $urandom, $urandom_range(63), 1'b0);
        add_item(htenc_pkg::MODE_ENCODE, 2, $urandom, $urandom_range(63), 1'b0);
        add_item(htenc_pkg::MODE_ENCODE, 3, $urandom, $urandom_range(63), 1'b0);
        add_item(htenc_pkg::MODE_ENCODE, 4, $urandom, $urandom_range(63), 1'b0);
        add_item(htenc_pkg::MODE_ENCODE, 7, $urandom, $urandom_range(63), 1'b0);
        add_item(htenc_pkg::MODE_ENCODE, 6, $urandom, $urandom_range(63), 1'b0);
        add_item(htenc_pkg::MODE_FLUSH, 7, $urandom, $urandom_range(63), 1'b0);
        add_item(unused_mode, $urandom_range(255), $urandom, $urandom_range(63), 1'b0);
        add_item(htenc_pkg::MODE_ENCODE, 5, $urandom, $urandom_range(63), 1'b0);
        add_item(htenc_pkg::MODE_ENCODE, 5, $urandom, $urandom_range(63), 1'b0);
        add_item(htenc_pkg::MODE_ENCODE, 5, $urandom, $urandom_range(63), 1'b0);
        add_item(htenc_pkg::MODE_FLUSH, 0, $urandom, $urandom_range(63), 1'b0);

        // random: mostly encodes of loaded symbols, loads, flushes, some noise
        useful = 0;
        while (useful < 300)
        begin
            sym = $urandom_range(99);
            if (sym < 3)
                add_item(unused_mode, $urandom_range(255), $urandom, $urandom_range(63),
                         1'b0);
            else
            begin
                if (sym < 22)
                    add_item(htenc_pkg::MODE_LOAD, $urandom_range(255), $urandom,
                             pick_code_len(), useful == 0 || useful == 200);
                else if (sym < 92)
                    add_item(htenc_pkg::MODE_ENCODE,
                             loaded_syms_q[$urandom_range(loaded_syms_q.size() - 1)],
                             $urandom, $urandom_range(63), useful == 0 || useful == 200);
                else
                    add_item(htenc_pkg::MODE_FLUSH, $urandom_range(255), $urandom,
                             $urandom_range(63), useful == 0 || useful == 200);
                useful++;
            end
        end
        add_item(htenc_pkg::MODE_FLUSH, 0, 32'h0, 0, 1'b0);

        // reset
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain and settle
        wait (taken_cnt == item_total);
        wait (packed_bytes_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
